// ===== hw/rtl/drn_pkg.sv =====
// ----------------------------------------------------------------------------
// drn_pkg: shared constants and helpers for the discounted return normalizer
// Episode depth, datapath widths, register indexes and saturation.
// ----------------------------------------------------------------------------
package drn_pkg;

   localparam int MAX_STEPS  = 64;
   localparam int IDX_W      = $clog2(MAX_STEPS);
   localparam int CNT_W      = $clog2(MAX_STEPS + 1);
   localparam int DATA_W     = 32;
   localparam int SUM_W      = DATA_W + IDX_W + 1;
   localparam int WIDE_W     = 64;
   localparam int DIV_STEP_W = $clog2(WIDE_W + 1);
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CSR_IDX_W  = 8;

   localparam logic [15:0] DISCOUNT_RESET = 16'd64880;

   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_EN    = 8'd1;

   function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      logic [DATA_W-1:0] r;
      if (x > $signed({{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (x < $signed({{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/drn_store.sv =====
// ----------------------------------------------------------------------------
// drn_store: episode store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drn_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [drn_pkg::IDX_W-1:0]     wr_addr,
   input  logic [drn_pkg::DATA_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [drn_pkg::IDX_W-1:0]     rd_addr,
   output logic [drn_pkg::DATA_W-1:0]    rd_data
);

   logic [drn_pkg::DATA_W-1:0] mem_ff [drn_pkg::MAX_STEPS];
   logic [drn_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/drn_div.sv =====
// ----------------------------------------------------------------------------
// drn_div: restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drn_pkg::WIDE_W-1:0]    dividend,
   input  logic [drn_pkg::DATA_W-1:0]    divisor,
   output logic [drn_pkg::WIDE_W-1:0]    quotient,
   output logic                          done
);

   logic [drn_pkg::DATA_W-1:0]     rem_ff, rem_in;
   logic [drn_pkg::WIDE_W-1:0]     quo_ff, quo_in;
   logic [drn_pkg::DATA_W-1:0]     dsr_ff;
   logic [drn_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic                           run_ff;
   logic                           done_ff;
   logic [drn_pkg::DATA_W:0]       shifted;
   logic                           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[drn_pkg::WIDE_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      rem_in  = fits ? 32'(shifted - {1'b0, dsr_ff}) : shifted[drn_pkg::DATA_W-1:0];
      quo_in  = {quo_ff[drn_pkg::WIDE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= drn_pkg::DIV_STEP_W'(drn_pkg::WIDE_W);
            rem_ff <= '0;
            quo_ff <= dividend;
            dsr_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == drn_pkg::DIV_STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hw/rtl/drn_sqrt.sv =====
// ----------------------------------------------------------------------------
// drn_sqrt: iterative integer square root
// Floor root of a 64 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module drn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drn_pkg::WIDE_W-1:0]    value,
   output logic [drn_pkg::DATA_W-1:0]    root,
   output logic                          done
);

   logic [drn_pkg::WIDE_W-1:0] v_ff, res_ff, bit_ff;
   logic [drn_pkg::WIDE_W-1:0] trial;
   logic                       run_ff;
   logic                       done_ff;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            v_ff   <= value;
            res_ff <= '0;
            bit_ff <= {2'b01, {(drn_pkg::WIDE_W-2){1'b0}}};
         end else if (run_ff) begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = res_ff[drn_pkg::DATA_W-1:0];
   assign done = done_ff;

endmodule

// ===== hw/rtl/discounted_return_normalizer.sv =====
// ----------------------------------------------------------------------------
// discounted_return_normalizer: episode return and standardization engine
// Collects rewards, scans back for discounted returns, optionally normalizes.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while idle; mid-episode items give no result.
// Episode end: a backward scan reads and adds each step, then each step is read and emitted.
// Normalization adds a sum pass, a mean divide, a variance pass, a divide and a root, plus a divide per step.
// busy stays high until the last result is issued; results cannot be stalled.
// Synchronous reset clears control state; the store holds no reset value.
module discounted_return_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [15:0]                req_reward,
   input  logic                              req_last_step,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_return_value,
   output logic                              rsp_last_result,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [drn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                       csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SC_RD, ST_SC_ADD, ST_SM_RD, ST_SM_ACC, ST_MN_GO, ST_MN_WAIT,
      ST_VR_RD, ST_VR_MUL, ST_VR_ACC, ST_VD_GO, ST_VD_WAIT, ST_RT_GO, ST_RT_WAIT,
      ST_NR_RD, ST_NR_GO, ST_NR_WAIT, ST_OT_RD, ST_OT_EM
   } state_type;

   state_type                         state_ff;
   logic [15:0]                       discount_ff;
   logic                              norm_en_ff;
   logic [drn_pkg::CNT_W-1:0]         fill_ff;
   logic [drn_pkg::CNT_W-1:0]         n_ff;
   logic [drn_pkg::IDX_W-1:0]         idx_ff;
   logic [drn_pkg::IDX_W-1:0]         last_ff;
   logic [drn_pkg::DATA_W-1:0]        acc_ff;
   logic signed [drn_pkg::SUM_W-1:0]  sum_ff;
   logic [drn_pkg::WIDE_W-1:0]        sq_ff;
   logic [drn_pkg::DATA_W-1:0]        mean_ff;
   logic [drn_pkg::DATA_W-1:0]        dev_ff;
   logic                              zero_out_ff;
   logic                              neg_ff;
   logic signed [drn_pkg::PROD_W-1:0] prod_ff;
   logic                              rsp_valid_ff;
   logic [drn_pkg::DATA_W-1:0]        rsp_value_ff;
   logic                              rsp_last_ff;

   logic                              wr_en, rd_en;
   logic [drn_pkg::IDX_W-1:0]         wr_addr, rd_addr;
   logic [drn_pkg::DATA_W-1:0]        wr_data, rd_data;
   logic signed [drn_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [drn_pkg::PROD_W-1:0] mul_p;
   logic                              div_start, div_done;
   logic [drn_pkg::WIDE_W-1:0]        div_dividend, div_q;
   logic [drn_pkg::DATA_W-1:0]        div_divisor;
   logic                              rt_start, rt_done;
   logic [drn_pkg::DATA_W-1:0]        rt_root;

   logic                              accept, ep_end;
   logic signed [drn_pkg::MUL_W-1:0]  diff;
   logic [drn_pkg::DATA_W-1:0]        mag;
   logic signed [drn_pkg::PROD_W-1:0] scan_sum;
   logic [drn_pkg::DATA_W-1:0]        scan_val;
   logic [drn_pkg::SUM_W-1:0]         sum_mag;
   logic [drn_pkg::WIDE_W:0]          sq_add;
   logic [drn_pkg::DATA_W-1:0]        norm_val;

   assign accept = start && (state_ff == ST_IDLE);
   assign ep_end = req_last_step ||
                   (fill_ff == drn_pkg::CNT_W'(drn_pkg::MAX_STEPS - 1));

   always_comb begin
      diff     = $signed({rd_data[31], rd_data}) - $signed({mean_ff[31], mean_ff});
      mag      = diff[drn_pkg::MUL_W-1] ? 32'(-diff) : diff[drn_pkg::DATA_W-1:0];
      scan_sum = $signed({{(drn_pkg::PROD_W-drn_pkg::DATA_W){rd_data[31]}}, rd_data})
                 + (prod_ff >>> 16);
      scan_val = drn_pkg::sat32(scan_sum);
      sum_mag  = sum_ff[drn_pkg::SUM_W-1] ? drn_pkg::SUM_W'(-sum_ff) : sum_ff;
      sq_add   = {1'b0, sq_ff} + {1'b0, prod_ff[drn_pkg::WIDE_W-1:0]};
      if (neg_ff) begin
         norm_val = (div_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_q);
      end else begin
         norm_val = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
   end

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = scan_val;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      mul_a        = $signed({17'b0, discount_ff});
      mul_b        = $signed({acc_ff[31], acc_ff});
      div_start    = 1'b0;
      div_dividend = {{(drn_pkg::WIDE_W-drn_pkg::SUM_W){1'b0}}, sum_mag};
      div_divisor  = {{(drn_pkg::DATA_W-drn_pkg::CNT_W){1'b0}}, n_ff};
      rt_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en   = accept;
            wr_addr = fill_ff[drn_pkg::IDX_W-1:0];
            wr_data = {{8{req_reward[15]}}, req_reward, 8'b0};
         end
         ST_SC_RD, ST_SM_RD, ST_VR_RD, ST_NR_RD, ST_OT_RD: begin
            rd_en = 1'b1;
         end
         ST_SC_ADD: begin
            wr_en = 1'b1;
         end
         ST_VR_MUL: begin
            mul_a = $signed({1'b0, mag});
            mul_b = $signed({1'b0, mag});
         end
         ST_MN_GO: begin
            div_start = 1'b1;
         end
         ST_VD_GO: begin
            div_start    = 1'b1;
            div_dividend = sq_ff;
         end
         ST_RT_GO: begin
            rt_start = 1'b1;
         end
         ST_NR_GO: begin
            div_start    = 1'b1;
            div_dividend = {16'b0, mag, 16'b0};
            div_divisor  = dev_ff;
         end
         ST_NR_WAIT: begin
            wr_en   = div_done;
            wr_data = norm_val;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         discount_ff  <= drn_pkg::DISCOUNT_RESET;
         norm_en_ff   <= 1'b0;
         fill_ff      <= '0;
         acc_ff       <= '0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            if (csr_index == drn_pkg::CSR_DISCOUNT) begin
               discount_ff <= csr_wdata;
            end else if (csr_index == drn_pkg::CSR_NORM_EN) begin
               norm_en_ff <= csr_wdata[0];
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (ep_end) begin
                     fill_ff     <= '0;
                     n_ff        <= fill_ff + 1'b1;
                     idx_ff      <= fill_ff[drn_pkg::IDX_W-1:0];
                     last_ff     <= fill_ff[drn_pkg::IDX_W-1:0];
                     acc_ff      <= '0;
                     zero_out_ff <= 1'b0;
                     state_ff    <= ST_SC_RD;
                  end else begin
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            ST_SC_RD: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SC_ADD;
            end
            ST_SC_ADD: begin
               acc_ff <= scan_val;
               if (idx_ff == '0) begin
                  state_ff <= norm_en_ff ? ST_SM_RD : ST_OT_RD;
                  sum_ff   <= '0;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= ST_SC_RD;
               end
            end
            ST_SM_RD: begin
               state_ff <= ST_SM_ACC;
            end
            ST_SM_ACC: begin
               sum_ff <= sum_ff + $signed({{(drn_pkg::SUM_W-drn_pkg::DATA_W){rd_data[31]}},
                                          rd_data});
               if (idx_ff == last_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_MN_GO;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_SM_RD;
               end
            end
            ST_MN_GO: begin
               neg_ff   <= sum_ff[drn_pkg::SUM_W-1];
               state_ff <= ST_MN_WAIT;
            end
            ST_MN_WAIT: begin
               if (div_done) begin
                  mean_ff  <= neg_ff ? 32'(-div_q) : div_q[31:0];
                  sq_ff    <= '0;
                  state_ff <= ST_VR_RD;
               end
            end
            ST_VR_RD: begin
               state_ff <= ST_VR_MUL;
            end
            ST_VR_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_VR_ACC;
            end
            ST_VR_ACC: begin
               sq_ff <= sq_add[drn_pkg::WIDE_W] ? '1 : sq_add[drn_pkg::WIDE_W-1:0];
               if (idx_ff == last_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_VD_GO;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_VR_RD;
               end
            end
            ST_VD_GO: begin
               state_ff <= ST_VD_WAIT;
            end
            ST_VD_WAIT: begin
               if (div_done) begin
                  state_ff <= ST_RT_GO;
               end
            end
            ST_RT_GO: begin
               state_ff <= ST_RT_WAIT;
            end
            ST_RT_WAIT: begin
               if (rt_done) begin
                  dev_ff <= rt_root;
                  if (rt_root == '0) begin
                     zero_out_ff <= 1'b1;
                     state_ff    <= ST_OT_RD;
                  end else begin
                     state_ff <= ST_NR_RD;
                  end
               end
            end
            ST_NR_RD: begin
               state_ff <= ST_NR_GO;
            end
            ST_NR_GO: begin
               neg_ff   <= diff[drn_pkg::MUL_W-1];
               state_ff <= ST_NR_WAIT;
            end
            ST_NR_WAIT: begin
               if (div_done) begin
                  if (idx_ff == last_ff) begin
                     idx_ff   <= '0;
                     state_ff <= ST_OT_RD;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_NR_RD;
                  end
               end
            end
            ST_OT_RD: begin
               state_ff <= ST_OT_EM;
            end
            ST_OT_EM: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= zero_out_ff ? '0 : rd_data;
               rsp_last_ff  <= (idx_ff == last_ff);
               if (idx_ff == last_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_OT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   drn_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   drn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   drn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (rt_start),
      .value (div_q),
      .root  (rt_root),
      .done  (rt_done)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_return_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

// ===== hw/rtl/drn_checker.sv =====
// ----------------------------------------------------------------------------
// drn_checker: port-level checks for the discounted return normalizer
// Watches the request, result and reset behavior seen at the top level.
// ----------------------------------------------------------------------------
module drn_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_last_step,
   input  logic                              rsp_valid,
   input  logic                              rsp_last_result
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> (!rsp_valid && !busy))
      else $error("result or busy after reset");

   a_end_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_step) |=> busy)
      else $error("episode end did not start processing");

   a_spaced_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in adjacent cycles");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> busy)
      else $error("idle before last result transfer");

endmodule

bind discounted_return_normalizer drn_checker u_drn_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_last_step   (req_last_step),
   .rsp_valid       (rsp_valid),
   .rsp_last_result (rsp_last_result)
);

// ===== bench/drn_return_checker.sv =====
// ----------------------------------------------------------------------------
// drn_return_checker: episode return predictor and result comparator
// Watches the command, result and register channels of the return normalizer.
// Keeps its own episode store and register copies, computes the discounted
// and optionally standardized returns when an episode closes, and compares
// every result transfer against the oldest predicted return.
// ----------------------------------------------------------------------------
module drn_return_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [15:0]            req_reward,
   input  logic                          req_last_step,
   input  logic                          rsp_valid,
   input  logic signed [31:0]            rsp_return_value,
   input  logic                          rsp_last_result,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [drn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata,
   output int                            fail_count,
   output int                            returns_pending
);

   typedef struct {
      logic signed [31:0] value;
      logic               last;
   } return_item_type;

   return_item_type return_queue[$];
   longint          step_store[drn_pkg::MAX_STEPS];
   int              step_count;
   logic [15:0]     gamma;
   logic            norm_on;

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   task automatic close_episode();
      longint          acc;
      longint          total;
      longint          mean;
      longint          diff;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned dev;
      return_item_type item;
      int              n;
      n   = step_count;
      acc = 0;
      for (int i = n - 1; i >= 0; i--) begin
         acc = clamp32(step_store[i] + ((longint'(gamma) * acc) >>> 16));
         step_store[i] = acc;
      end
      if (norm_on) begin
         total = 0;
         for (int i = 0; i < n; i++) total += step_store[i];
         mean = total / n;
         sq   = 0;
         for (int i = 0; i < n; i++) begin
            diff = step_store[i] - mean;
            if (diff < 0) diff = -diff;
            term = longint'(diff) * longint'(diff);
            sq   = (sq > 64'hFFFF_FFFF_FFFF_FFFF - term) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                         : sq + term;
         end
         dev = floor_root(sq / n);
         for (int i = 0; i < n; i++) begin
            if (dev == 0) step_store[i] = 0;
            else step_store[i] = clamp32(((step_store[i] - mean) * 65536) / longint'(dev));
         end
      end
      for (int i = 0; i < n; i++) begin
         item.value = step_store[i][31:0];
         item.last  = (i == n - 1);
         return_queue.insert(return_queue.size(), item);
      end
      step_count = 0;
   endtask

   task automatic report(input string what, input longint want, input longint got);
      if (fail_count < 10)
         $display("mismatch %s: expected %0d actual %0d", what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      return_item_type want;
      if (reset) begin
         return_queue.delete();
         step_count = 0;
         fail_count = 0;
         gamma      = drn_pkg::DISCOUNT_RESET;
         norm_on    = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == drn_pkg::CSR_DISCOUNT) gamma = csr_wdata;
            else if (csr_index == drn_pkg::CSR_NORM_EN) norm_on = csr_wdata[0];
         end
         if (rsp_valid) begin
            if (return_queue.size() == 0) begin
               report("unexpected return", 0, rsp_return_value);
            end else begin
               want = return_queue.pop_front();
               if (rsp_return_value !== want.value)
                  report("return_value", want.value, rsp_return_value);
               if (rsp_last_result !== want.last)
                  report("last_result", want.last, rsp_last_result);
            end
         end
         if (start && !busy) begin
            step_store[step_count] = longint'(req_reward) * 256;
            step_count++;
            if (req_last_step || step_count >= drn_pkg::MAX_STEPS) close_episode();
         end
      end
      returns_pending <= return_queue.size();
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top of the discounted return normalizer regression
// Drives whole episodes of rewards and register writes between episodes,
// with random idle bursts; the checker predicts and compares every return.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 1000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [15:0]            req_reward = '0;
   logic                          req_last_step = 1'b0;
   logic                          rsp_valid;
   logic signed [31:0]            rsp_return_value;
   logic                          rsp_last_result;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [drn_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]                   csr_wdata = '0;
   int                            fail_count;
   int                            returns_pending;
   int                            cycle_count = 0;
   int                            items_sent = 0;
   bit                            quiet_tail = 1'b0;

   discounted_return_normalizer dut (.*);

   drn_return_checker u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic idle_burst();
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_step(input logic [15:0] reward, input logic last);
      req_reward    <= reward;
      req_last_step <= last;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      idle_burst();
   endtask

   task automatic write_reg(input logic [drn_pkg::CSR_IDX_W-1:0] index,
                            input logic [15:0] data);
      start <= 1'b0;
      @(posedge clock);
      while (returns_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_reward();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_episode(input int len);
      for (int i = 0; i < len; i++)
         send_step(pick_reward(), (i == len - 1) && (len < drn_pkg::MAX_STEPS));
   endtask

   initial begin
      int len;
      int sel;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero deviation, out-of-range index
      send_step(16'h7FFF, 1'b1);
      send_step(16'h8000, 1'b1);
      send_step(16'h7FFF, 1'b0);
      send_step(16'h7FFF, 1'b0);
      send_step(16'h7FFF, 1'b1);
      write_reg(drn_pkg::CSR_DISCOUNT, 16'hFFFF);
      send_step(16'h8000, 1'b0);
      send_step(16'h8000, 1'b0);
      send_step(16'h8000, 1'b1);
      write_reg(drn_pkg::CSR_NORM_EN, 16'h0001);
      send_step(16'h0100, 1'b1);
      send_step(16'h0000, 1'b0);
      send_step(16'h0000, 1'b0);
      send_step(16'h0000, 1'b1);
      write_reg(drn_pkg::CSR_DISCOUNT, 16'h0000);
      send_step(16'h7FFF, 1'b0);
      send_step(16'h8000, 1'b0);
      send_step(16'h1234, 1'b1);
      write_reg(8'hFF, 16'hFFFF);
      write_reg(8'hFE, 16'h0000);
      send_step(16'h4000, 1'b0);
      send_step(16'hC000, 1'b1);
      write_reg(drn_pkg::CSR_NORM_EN, 16'hFFFE);
      send_episode(drn_pkg::MAX_STEPS);

      // random episodes, registers changed between some of them
      while (items_sent < 300) begin
         if (items_sent > 250) quiet_tail = 1'b1;
         sel = $urandom_range(0, 19);
         if (sel == 0) len = drn_pkg::MAX_STEPS;
         else if (sel < 4) len = $urandom_range(9, drn_pkg::MAX_STEPS - 1);
         else len = $urandom_range(1, 8);
         send_episode(len);
         if ($urandom_range(0, 3) == 0) begin
            sel = $urandom_range(0, 5);
            if (sel == 0) write_reg(drn_pkg::CSR_DISCOUNT, 16'h0000);
            else if (sel == 1) write_reg(drn_pkg::CSR_DISCOUNT, 16'hFFFF);
            else if (sel == 2) write_reg(drn_pkg::CSR_DISCOUNT, 16'($urandom));
            else if (sel == 3) write_reg(drn_pkg::CSR_NORM_EN, 16'($urandom));
            else if (sel == 4) write_reg(8'($urandom_range(2, 255)), 16'($urandom));
            else write_reg(drn_pkg::CSR_NORM_EN, 16'h0001);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (returns_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
